>>> src/srs_pkg.sv
// Shared types and constants for the shutter release sequencer.
// Request and result payload structs, phase and kind codes, timing constants.
// No dependencies.
package srs_pkg;

   localparam int unsigned FocusWidth   = 16;
   localparam int unsigned ExpDsWidth   = 16;
   localparam int unsigned ElapsedWidth = 23;
   localparam int unsigned PhaseWidth   = 3;
   localparam int unsigned KindWidth    = 2;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [FocusWidth-1:0] FocusReset = 16'd100;
   localparam logic [6:0]            MsPerDs    = 7'd100;

   localparam logic [KindWidth-1:0] KindTick   = 2'd0;
   localparam logic [KindWidth-1:0] KindStart  = 2'd1;
   localparam logic [KindWidth-1:0] KindCancel = 2'd2;

   localparam logic [PhaseWidth-1:0] PhaseIdle     = 3'd0;
   localparam logic [PhaseWidth-1:0] PhasePre      = 3'd1;
   localparam logic [PhaseWidth-1:0] PhaseExpose   = 3'd2;
   localparam logic [PhaseWidth-1:0] PhasePost     = 3'd3;
   localparam logic [PhaseWidth-1:0] PhaseFinished = 3'd4;

   // register word index of focus_ms
   localparam logic RegFocus = 1'b0;

   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic [ExpDsWidth-1:0] exposure_ds;
   } req_data_type;

   typedef struct packed {
      logic                  half_press;
      logic                  full_press;
      logic                  done_res;
      logic [PhaseWidth-1:0] phase;
   } rsp_data_type;

endpackage

>>> src/srs_seq.sv
// Phase sequencer: holds phase, elapsed count and exposure length, and forms
// the result for the request being accepted. Depends on srs_pkg.
module srs_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  srs_pkg::req_data_type req_data,
   input  logic [srs_pkg::FocusWidth-1:0] focus_ms,
   output srs_pkg::rsp_data_type result
);
   import srs_pkg::*;

   logic [PhaseWidth-1:0]   phase_ff, phase_in;
   logic [ElapsedWidth-1:0] elapsed_ff, elapsed_in;
   logic [ElapsedWidth-1:0] exposure_ff, exposure_in;
   logic [ElapsedWidth-1:0] elapsed_inc;
   logic [ElapsedWidth-1:0] focus_ext;
   logic [ElapsedWidth-1:0] exposure_new;
   logic                    done;

   assign focus_ext    = {{(ElapsedWidth-FocusWidth){1'b0}}, focus_ms};
   // 65535 * 100 fits in 23 bits
   assign exposure_new = ElapsedWidth'(req_data.exposure_ds) * MsPerDs;
   // saturating count
   assign elapsed_inc  = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;

   always_comb begin
      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      exposure_in = exposure_ff;
      done        = 1'b0;
      unique case (req_data.kind)
         KindTick: begin
            unique case (phase_ff)
               PhasePre: begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc > focus_ext) begin
                     phase_in   = PhaseExpose;
                     elapsed_in = '0;
                  end
               end
               PhaseExpose: begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc > exposure_ff) begin
                     phase_in   = PhasePost;
                     elapsed_in = '0;
                  end
               end
               PhasePost: begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc > focus_ext) begin
                     phase_in = PhaseFinished;
                  end
               end
               PhaseFinished: begin
                  done     = 1'b1;
                  phase_in = PhaseIdle;
               end
               default: phase_in = PhaseIdle;
            endcase
         end
         KindStart: begin
            if (phase_ff == PhaseIdle || phase_ff > PhaseFinished) begin
               exposure_in = exposure_new;
               phase_in    = PhasePre;
               elapsed_in  = '0;
            end
         end
         KindCancel: begin
            if (phase_ff == PhaseIdle || phase_ff > PhaseFinished) begin
               done     = 1'b1;
               phase_in = PhaseIdle;
            end else if (phase_ff == PhaseExpose) begin
               phase_in   = PhasePost;
               elapsed_in = '0;
            end else begin
               phase_in = PhaseFinished;
            end
         end
         default: begin
            if (phase_ff > PhaseFinished) phase_in = PhaseIdle;
         end
      endcase
   end

   always_comb begin
      result.half_press = (phase_in == PhasePre) || (phase_in == PhaseExpose) ||
                          (phase_in == PhasePost);
      result.full_press = (phase_in == PhaseExpose);
      result.done_res   = done;
      result.phase      = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhaseIdle;
         elapsed_ff  <= '0;
         exposure_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         elapsed_ff  <= elapsed_in;
         exposure_ff <= exposure_in;
      end
   end

`ifndef SYNTHESIS
   // exposing always holds both lines
   a_expose_lines: assert property (@(posedge clock) disable iff (reset)
      accept && result.full_press |-> result.half_press && result.phase == PhaseExpose)
      else $error("full press outside exposure");
   // done only when the sequencer ends up idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      accept && result.done_res |=> phase_ff == PhaseIdle)
      else $error("done without return to idle");
   // a start from idle always enters pre-focus with a cleared count
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == KindStart && phase_ff == PhaseIdle
      |=> phase_ff == PhasePre && elapsed_ff == '0)
      else $error("start did not enter pre-focus");
`endif

endmodule

>>> src/shutter_release_sequencer_top.sv
// Top level of the shutter release sequencer: request/result channels,
// CSR port for focus_ms and the result register. Depends on srs_pkg, srs_seq.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_data (kind, exposure_ds)
//   rsp      out        rsp_valid/stall    rsp_data (half/full press, done, phase)
//   csr      in/out     APB, pready = 1    focus_ms at byte address 0
//
// One request per cycle while req_stall is low; each yields its result next cycle from
// the result register. The phase compare-and-advance is a single pass of logic.
// Synchronous reset puts the phase at idle, clears the counts, focus_ms = 100.
// A stalled result holds the request side only while the result register is full.
module shutter_release_sequencer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  srs_pkg::req_data_type                 req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output srs_pkg::rsp_data_type                 rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [srs_pkg::CsrAddrWidth-1:0]      paddr,
   input  logic [srs_pkg::CsrDataWidth-1:0]      pwdata,
   output logic [srs_pkg::CsrDataWidth-1:0]      prdata,
   output logic                                  pready
);
   import srs_pkg::*;

   logic [FocusWidth-1:0] focus_ff;
   logic                  rsp_valid_ff;
   rsp_data_type          rsp_data_ff;
   rsp_data_type          result;
   logic                  req_accept;
   logic                  csr_write;
   logic                  csr_word;

   assign csr_word  = paddr[CsrAddrWidth-1];
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (csr_word == RegFocus) ?
                      {{(CsrDataWidth-FocusWidth){1'b0}}, focus_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         focus_ff <= FocusReset;
      end else if (csr_write && csr_word == RegFocus) begin
         focus_ff <= pwdata[FocusWidth-1:0];
      end
   end

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   srs_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_data (req_data),
      .focus_ms (focus_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // every accepted request shows up as a result next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted request produced no result");
   // a held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !req_accept)
      else $error("request accepted over a stalled result");
   // done pulse is reported only with the idle phase
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.phase == PhaseIdle &&
                                         !rsp_data.half_press)
      else $error("done reported outside idle");
`endif

endmodule

>>> tb/sv/srs_scoreboard_pkg.sv
// Scoreboard for the shutter release sequencer testbench: tracks phase, elapsed
// and exposure counts per request and checks each result against them.
// Depends on srs_pkg.
package srs_scoreboard_pkg;
   import srs_pkg::*;

   class release_scoreboard;
      logic [FocusWidth-1:0]   focus_ms;
      logic [PhaseWidth-1:0]   phase_q;
      logic [ElapsedWidth-1:0] elapsed_q;
      logic [ElapsedWidth-1:0] exposure_q;
      rsp_data_type            pending_levels[$];
      int unsigned             mismatches;
      int unsigned             checked;
      int unsigned             done_pulses;

      function new();
         focus_ms    = FocusReset;
         phase_q     = PhaseIdle;
         elapsed_q   = '0;
         exposure_q  = '0;
         mismatches  = 0;
         checked     = 0;
         done_pulses = 0;
      endfunction

      function void set_focus(input logic [FocusWidth-1:0] value);
         focus_ms = value;
      endfunction

      function int unsigned pending();
         return pending_levels.size();
      endfunction

      // elapsed count saturates rather than wrapping
      function void count_ms();
         if (elapsed_q != '1) elapsed_q = elapsed_q + 1'b1;
      endfunction

      function void note_request(input req_data_type r);
         rsp_data_type want;
         logic         done_now;
         done_now = 1'b0;
         if (phase_q > PhaseFinished) phase_q = PhaseIdle;
         case (r.kind)
            KindTick: begin
               case (phase_q)
                  PhasePre: begin
                     count_ms();
                     if (elapsed_q > focus_ms) begin
                        phase_q   = PhaseExpose;
                        elapsed_q = '0;
                     end
                  end
                  PhaseExpose: begin
                     count_ms();
                     if (elapsed_q > exposure_q) begin
                        phase_q   = PhasePost;
                        elapsed_q = '0;
                     end
                  end
                  PhasePost: begin
                     count_ms();
                     if (elapsed_q > focus_ms) phase_q = PhaseFinished;
                  end
                  PhaseFinished: begin
                     done_now = 1'b1;
                     phase_q  = PhaseIdle;
                  end
                  default: ;
               endcase
            end
            KindStart: begin
               if (phase_q == PhaseIdle) begin
                  exposure_q = ElapsedWidth'(32'(r.exposure_ds) * 32'(MsPerDs));
                  phase_q    = PhasePre;
                  elapsed_q  = '0;
               end
            end
            KindCancel: begin
               if (phase_q == PhaseIdle) begin
                  done_now = 1'b1;
               end else if (phase_q == PhaseExpose) begin
                  phase_q   = PhasePost;
                  elapsed_q = '0;
               end else begin
                  phase_q = PhaseFinished;
               end
            end
            default: ;
         endcase
         want.half_press = (phase_q == PhasePre) || (phase_q == PhaseExpose) ||
                           (phase_q == PhasePost);
         want.full_press = (phase_q == PhaseExpose);
         want.done_res   = done_now;
         want.phase      = phase_q;
         if (done_now) done_pulses++;
         pending_levels.push_back(want);
      endfunction

      function void check_levels(input rsp_data_type got);
         rsp_data_type want;
         if (pending_levels.size() == 0) begin
            $error("result with no request outstanding: phase %0d", got.phase);
            mismatches++;
            return;
         end
         want = pending_levels.pop_front();
         checked++;
         if (got.half_press !== want.half_press) begin
            $error("half_press: expected %0d, got %0d", want.half_press, got.half_press);
            mismatches++;
         end
         if (got.full_press !== want.full_press) begin
            $error("full_press: expected %0d, got %0d", want.full_press, got.full_press);
            mismatches++;
         end
         if (got.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
            mismatches++;
         end
         if (got.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, got.phase);
            mismatches++;
         end
      endfunction
   endclass

endpackage

>>> tb/sv/tb.sv
// Top-level testbench for shutter_release_sequencer_top: drives requests and
// focus_ms writes, checks every result. Depends on srs_pkg, srs_scoreboard_pkg.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import srs_pkg::*;
   import srs_scoreboard_pkg::*;

   localparam logic [KindWidth-1:0]    KindUnused    = 2'd3;
   localparam logic [CsrAddrWidth-1:0] FocusAddr     = CsrAddrWidth'(4 * RegFocus);
   localparam int unsigned             WatchdogLimit = 2000;
   localparam int unsigned             PhaseItems    = 190;
   localparam int unsigned             SeqTickCap    = 300;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_data_type            req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_data_type            rsp_data;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [CsrDataWidth-1:0] pwdata = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   release_scoreboard       sb;
   logic                    idle_on = 1'b1;
   logic [FocusWidth-1:0]   focus_now = FocusReset;
   int unsigned             requests_sent = 0;
   int unsigned             settings_used = 0;
   int unsigned             csr_errors = 0;
   int unsigned             quiet_cycles = 0;

   shutter_release_sequencer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 16);
   end

   // monitor: predict on accepted request, check accepted result, track writes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_levels(rsp_data);
         if (psel && penable && pwrite && pready && paddr == FocusAddr)
            sb.set_focus(pwdata[FocusWidth-1:0]);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WatchdogLimit) begin
            $error("watchdog: no progress for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_request(input logic [KindWidth-1:0] kind,
                               input logic [ExpDsWidth-1:0] ds);
      if (idle_on) begin
         while ($urandom_range(99) < 16) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: kind, exposure_ds: ds};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [FocusWidth-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= FocusAddr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== CsrDataWidth'(want)) begin
         $error("focus_ms: expected %0d, got %0d", want, prdata);
         csr_errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_write_focus(input logic [FocusWidth-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= FocusAddr;
      pwdata  <= CsrDataWidth'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      focus_now = value;
      settings_used++;
      csr_read_check(value);
   endtask

   // start, then enough ticks to run the whole press; long ones get cut short
   task automatic run_sequence();
      logic [ExpDsWidth-1:0] ds;
      int unsigned           exposure_len;
      int unsigned           ticks_needed;
      int unsigned           n;
      int unsigned           pick;
      ds = ($urandom_range(9) < 7) ? ExpDsWidth'($urandom_range(3))
                                   : ExpDsWidth'($urandom());
      send_request(KindStart, ds);
      exposure_len = 32'(ds) * 32'(MsPerDs);
      ticks_needed = 2 * 32'(focus_now) + exposure_len + 6;
      n = (ticks_needed > SeqTickCap) ? $urandom_range(SeqTickCap, 10) : ticks_needed;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 2)
            send_request(KindCancel, ExpDsWidth'($urandom()));
         else if (pick < 4)
            send_request(KindStart, ExpDsWidth'($urandom()));
         else if (pick < 5)
            send_request(KindUnused, ExpDsWidth'($urandom()));
         else
            send_request(KindTick, ExpDsWidth'($urandom()));
      end
      if (n < ticks_needed) begin
         send_request(KindCancel, '0);
         send_request(KindCancel, '0);
         send_request(KindTick, '0);
      end
   endtask

   initial begin
      logic [FocusWidth-1:0] settings[5];
      int unsigned           target;
      settings = '{16'd0, 16'hFFFF, 16'd3, 16'd0, FocusReset};
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_read_check(FocusReset);
      csr_write_focus(16'd1);

      // directed: every kind from idle, tick in every phase, cancel in pre, expose and post; both exposure extremes
      send_request(KindTick, 16'h0000);
      send_request(KindCancel, 16'hFFFF);
      send_request(KindUnused, 16'hFFFF);
      send_request(KindStart, 16'h0000);
      send_request(KindStart, 16'hFFFF);
      repeat (2) send_request(KindTick, 16'hFFFF);
      send_request(KindTick, 16'h0000);
      repeat (2) send_request(KindTick, 16'h0000);
      send_request(KindUnused, 16'h0000);
      send_request(KindTick, 16'h0000);
      send_request(KindStart, 16'hFFFF);
      send_request(KindCancel, 16'h0000);
      send_request(KindStart, 16'h0001);
      send_request(KindTick, 16'h0000);
      send_request(KindStart, 16'h0001);
      repeat (2) send_request(KindTick, 16'h0000);
      send_request(KindCancel, 16'h0000);
      send_request(KindCancel, 16'h0000);
      send_request(KindTick, 16'h0000);

      for (int p = 0; p < 5; p++) begin
         wait_drained();
         csr_write_focus((p == 3) ? FocusWidth'($urandom_range(12, 1)) : settings[p]);
         idle_on = (p != 2);
         target  = requests_sent + PhaseItems;
         while (requests_sent < target) begin
            if ($urandom_range(9) == 0)
               send_request(KindWidth'($urandom_range(3)), ExpDsWidth'($urandom()));
            else
               run_sequence();
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      $display("Sent %0d requests under %0d focus_ms settings; %0d results checked,",
               requests_sent, settings_used, sb.checked);
      $display("%0d done pulses expected along the way.", sb.done_pulses);
      if (sb.mismatches == 0 && csr_errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
